[hw/rtl/amssb_pkg.sv]
// Shared types, constants and saturation helper for the AM/SSB demodulator.
package amssb_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int DECIMATION_DEF = 4;
   localparam int N_TAPS         = 31;
   localparam int Q_DEPTH        = 16;
   localparam int N_PAIRS        = 8;
   localparam int COEF_W         = 15;
   localparam int ACC_W          = 32;
   localparam int SHIFT          = 15;

   localparam logic MODE_SSB = 1'b0;
   localparam logic MODE_AM  = 1'b1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SAMPLE_W+1:0] wide_type;

   localparam wide_type SAT_POS = 18'sd32767;
   localparam wide_type SAT_NEG = -18'sd32767;

   // symmetric clip to +-32767
   function automatic sample_type sat_sym(input wide_type v);
      sample_type r;
      if (v > SAT_POS) begin
         r = sample_type'(SAT_POS);
      end else if (v < SAT_NEG) begin
         r = sample_type'(SAT_NEG);
      end else begin
         r = sample_type'(v);
      end
      return r;
   endfunction

endpackage

[hw/rtl/am_ssb_demod_decimator.sv]
// Top level of the decimating AM / SSB I/Q demodulator.
// One I/Q transaction in gives one sample out, one transaction per cycle sustained while
// rsp_ready is high; it goes through the input register, then the result register,
// all arithmetic in one pass between them. Only every DECIMATION-th transaction is
// demodulated; the others return zero and leave the delay lines alone. csr_wr_data selects
// the mode: 0 is SSB (31-tap Hilbert of I, >>>15, plus Q delayed 15 demod steps, clipped
// to +-32767), 1 is AM (31/32 max + 3/8 min of |I|,|Q|, clipped to 32767). Delay lines
// hold their contents while AM is selected. Change mode only while the block is idle.
module am_ssb_demod_decimator import amssb_pkg::*; #(
   parameter int DECIMATION = DECIMATION_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  sample_type req_i_sample,
   input  sample_type req_q_sample,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output sample_type rsp_out_sample,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);

   localparam int PH_W = $clog2(DECIMATION + 1);
   localparam logic [PH_W-1:0] PH_LAST = PH_W'(DECIMATION - 1);

   logic             mode_ff;
   logic             s1_vld_ff, s1_vld_in;
   sample_type       s1_i_ff, s1_q_ff;
   logic [PH_W-1:0]  phase_ff, phase_in;
   logic             rsp_vld_ff, rsp_vld_in;
   sample_type       rsp_ff, rsp_in;

   logic             s1_adv;
   logic             demod_step;
   logic             ssb_shift;
   sample_type       ssb_sample;

   logic [SAMPLE_W:0]   ext_i, ext_q, abs_i, abs_q, hi, lo;
   logic [SAMPLE_W+5:0] hi31;
   logic [SAMPLE_W+1:0] lo3;
   logic [SAMPLE_W:0]   am_sum;
   sample_type          am_sample;

   // stage 1 moves on when the result register is free or being drained
   assign s1_adv     = s1_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready  = !s1_vld_ff || s1_adv;
   assign demod_step = (phase_ff == PH_LAST);
   assign ssb_shift  = s1_adv && demod_step && (mode_ff == MODE_SSB);

   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (req_valid && req_ready) begin
         s1_vld_in = 1'b1;
      end else if (s1_adv) begin
         s1_vld_in = 1'b0;
      end
      phase_in = phase_ff;
      if (s1_adv) begin
         phase_in = demod_step ? '0 : phase_ff + 1'b1;
      end
      rsp_vld_in = rsp_vld_ff;
      if (s1_adv) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   amssb_hilbert u_hilbert (
      .clock      (clock),
      .reset      (reset),
      .shift_en   (ssb_shift),
      .i_sample   (s1_i_ff),
      .q_sample   (s1_q_ff),
      .ssb_sample (ssb_sample)
   );

   // alpha-max-beta-min; |-32768| needs the 17th bit
   always_comb begin
      ext_i  = {s1_i_ff[SAMPLE_W-1], s1_i_ff};
      ext_q  = {s1_q_ff[SAMPLE_W-1], s1_q_ff};
      abs_i  = ext_i[SAMPLE_W] ? (~ext_i + 1'b1) : ext_i;
      abs_q  = ext_q[SAMPLE_W] ? (~ext_q + 1'b1) : ext_q;
      hi     = (abs_i > abs_q) ? abs_i : abs_q;
      lo     = (abs_i > abs_q) ? abs_q : abs_i;
      hi31   = {hi, 5'b0} - {5'b0, hi};
      lo3    = {lo, 1'b0} + {1'b0, lo};
      am_sum = hi31[SAMPLE_W+5:5] + {2'b0, lo3[SAMPLE_W+1:3]};
      am_sample = sat_sym(wide_type'({1'b0, am_sum}));
   end

   always_comb begin
      rsp_in = '0;
      if (demod_step) begin
         rsp_in = (mode_ff == MODE_AM) ? am_sample : ssb_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_SSB;
         s1_vld_ff  <= 1'b0;
         phase_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         s1_vld_ff  <= s1_vld_in;
         phase_ff   <= phase_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_i_ff <= req_i_sample;
         s1_q_ff <= req_q_sample;
      end
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_out_sample = rsp_ff;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_LAST)
      else $error("phase counter out of range");

   a_zero_off_step: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && !demod_step) |=> (rsp_out_sample == '0))
      else $error("non-demod transaction gave nonzero sample");

   a_am_positive: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && demod_step && mode_ff == MODE_AM) |=> !rsp_out_sample[SAMPLE_W-1])
      else $error("AM magnitude negative");

   a_no_min_neg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_sample != 16'h8000))
      else $error("output escaped saturation");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_vld_ff && rsp_vld_ff && !rsp_ready))
      else $error("input stalled without back-pressure");

endmodule

[hw/rtl/amssb_hilbert.sv]
// I/Q delay lines and 31-tap odd-tap Hilbert sum for the SSB path.
module amssb_hilbert import amssb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       shift_en,
   input  sample_type i_sample,
   input  sample_type q_sample,
   output sample_type ssb_sample
);

   sample_type i_line_ff [N_TAPS];
   sample_type q_line_ff [Q_DEPTH];
   sample_type i_line_in [N_TAPS];
   sample_type q_line_in [Q_DEPTH];

   logic signed [SAMPLE_W:0]  diff  [N_PAIRS];
   logic signed [ACC_W-1:0]   prod  [N_PAIRS];
   logic signed [ACC_W-1:0]   acc;
   logic signed [ACC_W-SHIFT-1:0] hv;
   wide_type                  sum;

   function automatic logic [COEF_W-1:0] hilb_coef(input logic [2:0] k);
      logic [COEF_W-1:0] c;
      case (k)
         3'd0:    c = 15'd1293;
         3'd1:    c = 15'd1492;
         3'd2:    c = 15'd1763;
         3'd3:    c = 15'd2155;
         3'd4:    c = 15'd2771;
         3'd5:    c = 15'd3879;
         3'd6:    c = 15'd6466;
         3'd7:    c = 15'd19398;
         default: c = '0;
      endcase
      return c;
   endfunction

   // line contents as they stand after this step's shift
   always_comb begin
      i_line_in[0] = i_sample;
      for (int j = 1; j < N_TAPS; j++) begin
         i_line_in[j] = i_line_ff[j-1];
      end
      q_line_in[0] = q_sample;
      for (int j = 1; j < Q_DEPTH; j++) begin
         q_line_in[j] = q_line_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < N_TAPS; j++) begin
            i_line_ff[j] <= '0;
         end
         for (int j = 0; j < Q_DEPTH; j++) begin
            q_line_ff[j] <= '0;
         end
      end else if (shift_en) begin
         i_line_ff <= i_line_in;
         q_line_ff <= q_line_in;
      end
   end

   // antisymmetric pairs: older tap minus newer tap, times constant
   always_comb begin
      acc = '0;
      for (int k = 0; k < N_PAIRS; k++) begin
         diff[k] = {i_line_in[N_TAPS-1-2*k][SAMPLE_W-1], i_line_in[N_TAPS-1-2*k]}
                 - {i_line_in[2*k][SAMPLE_W-1], i_line_in[2*k]};
         prod[k] = $signed({{(ACC_W-SAMPLE_W-1){diff[k][SAMPLE_W]}}, diff[k]})
                 * $signed({{(ACC_W-COEF_W){1'b0}}, hilb_coef(3'(k))});
         acc     = acc + prod[k];
      end
      hv  = acc[ACC_W-1:SHIFT];
      sum = wide_type'(hv) + wide_type'(q_line_in[Q_DEPTH-1]);
   end

   assign ssb_sample = sat_sym(sum);

endmodule
